// ===== design/bircrl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the binary image run-length projection block.
// Depends on nothing; every other file in design/ uses it.
package bircrl_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WSIZE_W = COL_W + 1;
    localparam int HSIZE_W = ROW_W + 1;

    localparam int COLOR_W  = 8;
    localparam int SUM_W    = 10;
    localparam int THRESH_W = 10;
    localparam int DIM_W    = 9;
    localparam int COUNT_W  = 9;
    localparam int ORD_W    = 7;
    localparam int LINE_W   = 8;

    localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;
    localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(450);
    localparam logic [DIM_W-1:0]    WIDTH_RESET   = DIM_W'(256);
    localparam logic [DIM_W-1:0]    HEIGHT_RESET  = DIM_W'(256);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } cfg_index_t;

    // open run of one line
    typedef struct packed {
        logic [ORD_W-1:0]   ord;
        logic [COUNT_W-1:0] cnt;
    } run_state_t;

    typedef struct packed {
        logic               is_column;
        logic [LINE_W-1:0]  line_index;
        logic [ORD_W-1:0]   run_index;
        logic [COUNT_W-1:0] run_length;
        logic               last;
    } result_t;

endpackage

// ===== design/bircrl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input and run result output.
// Depends on bircrl_pkg for field widths.
interface bircrl_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [bircrl_pkg::COLOR_W-1:0] red;
    logic [bircrl_pkg::COLOR_W-1:0] green;
    logic [bircrl_pkg::COLOR_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bircrl_result_if;
    logic                           valid;
    logic                           ready;
    logic                           is_column;
    logic [bircrl_pkg::LINE_W-1:0]  line_index;
    logic [bircrl_pkg::ORD_W-1:0]   run_index;
    logic [bircrl_pkg::COUNT_W-1:0] run_length;
    logic                           last;

    modport source (output valid, is_column, line_index, run_index, run_length, last,
                    input ready);
    modport sink   (input valid, is_column, line_index, run_index, run_length, last,
                    output ready);
endinterface

// ===== design/bircrl_cell.sv =====
`timescale 1ns / 1ps
// One column cell of the rotating run-state ring.
// Depends on bircrl_pkg for run_state_t and widths.
module bircrl_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bircrl_pkg::COL_W-1:0]  idx,
    input  logic [bircrl_pkg::WSIZE_W-1:0] ring_len,
    input  logic                          shift,
    input  bircrl_pkg::run_state_t        nbr,
    input  bircrl_pkg::run_state_t        fb,
    output bircrl_pkg::run_state_t        q
);
    import bircrl_pkg::*;

    run_state_t state_reg;
    run_state_t state_next;
    logic       active;
    logic       tail;

    assign active = {1'b0, idx} < ring_len;
    assign tail   = {1'b0, idx} == (ring_len - WSIZE_W'(1));

    // on a shift, the tail of the ring takes the fed-back head entry, the other active cells move one step
    always_comb
    begin
        if (!shift || !active)
            state_next = state_reg;
        else if (tail)
            state_next = fb;
        else
            state_next = nbr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    assign q = state_reg;

endmodule

// ===== design/bircrl_out_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, sends one beat per cycle while ready is high.
// Depends on bircrl_pkg and bircrl_result_if.
module bircrl_out_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_cnt,
    input  bircrl_pkg::result_t    push_a,
    input  bircrl_pkg::result_t    push_b,
    output logic                   room,
    bircrl_result_if.source        result
);
    import bircrl_pkg::*;

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FCNT_W-1:0]  count_reg;
    logic [FCNT_W-1:0]  count_next;
    logic               pop;
    result_t            head;

    assign pop  = result.valid && result.ready;
    assign room = count_reg <= FCNT_W'(FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + FCNT_W'(push_cnt) - FCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push_a;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head              = mem_reg[rd_ptr_reg];
    assign result.valid      = count_reg != '0;
    assign result.is_column  = head.is_column;
    assign result.line_index = head.line_index;
    assign result.run_index  = head.run_index;
    assign result.run_length = head.run_length;
    assign result.last       = head.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> (count_reg + FCNT_W'(push_cnt)) <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

// ===== design/binary_image_row_column_run_lengths_core.sv =====
`timescale 1ns / 1ps
// Run-length projection of a binary image: row runs and column runs of black pixels.
// A pixel's results are registered in the result queue and offered from its head.
// Throughput: one pixel per cycle while the queue has room and the ring is aligned; the output
//   moves one beat per cycle while ready is high, so a pixel closing both runs pushes two results (4-entry queue).
// Reset clears all column cells at once. A width change in mid-row realigns the
//   column ring first, and no pixel is taken while it does.
module binary_image_row_column_run_lengths_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bircrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bircrl_pkg::CFG_DATA_W-1:0]  cfg_data,
    bircrl_pixel_if.sink                       pixel,
    bircrl_result_if.source                    result
);
    import bircrl_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_DOWN = 3'b010,
        ST_UP   = 3'b100
    } sweep_state_t;

    logic [THRESH_W-1:0] thresh_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    sweep_state_t        state_reg;
    sweep_state_t        state_next;
    logic [COL_W-1:0]    sw_reg;
    logic [COL_W-1:0]    sw_next;
    logic [WSIZE_W-1:0]  ring_len_reg;
    logic [WSIZE_W-1:0]  ring_len_next;

    logic [COL_W-1:0]    col_pos_reg;
    logic [COL_W-1:0]    col_pos_next;
    logic [ROW_W-1:0]    row_pos_reg;
    logic [ROW_W-1:0]    row_pos_next;
    run_state_t          row_run_reg;
    run_state_t          row_run_next;

    logic [WSIZE_W-1:0]  w_eff;
    logic [HSIZE_W-1:0]  h_eff;
    logic [WSIZE_W-1:0]  col_plus;
    logic [WSIZE_W-1:0]  target;
    logic [SUM_W-1:0]    sum;
    logic                black;
    logic                row_end;
    logic                col_end;
    logic                accept;
    logic                room;
    logic                shift;

    run_state_t          chain_q [MAX_WIDTH];
    run_state_t          head;
    run_state_t          col_upd;
    run_state_t          fb;
    logic [COUNT_W-1:0]  row_cnt_inc;
    logic [COUNT_W-1:0]  col_cnt_inc;
    logic                emit_r;
    logic                emit_c;
    result_t             row_res;
    result_t             col_res;
    result_t             push_a;
    result_t             push_b;
    logic [1:0]          push_cnt;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                CFG_WIDTH:     width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    height_reg <= cfg_data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WSIZE_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WSIZE_W'(MAX_WIDTH);
        else
            w_eff = WSIZE_W'(width_reg);

        if (height_reg == '0)
            h_eff = HSIZE_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HSIZE_W'(MAX_HEIGHT);
        else
            h_eff = HSIZE_W'(height_reg);
    end

    assign sum     = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);
    assign black   = sum <= thresh_reg;
    assign row_end = {1'b0, col_pos_reg} >= (w_eff - WSIZE_W'(1));
    assign col_end = {1'b0, row_pos_reg} >= (h_eff - HSIZE_W'(1));

    // ring length the current position needs: never shorter than the position itself
    assign col_plus = {1'b0, col_pos_reg} + WSIZE_W'(1);
    assign target   = (col_pos_reg == '0) ? w_eff :
                      ((col_plus > w_eff) ? col_plus : w_eff);

    assign pixel.ready = (state_reg == ST_RUN) && (target == ring_len_reg) && room;
    assign accept      = pixel.valid && pixel.ready;
    assign shift       = accept || (state_reg != ST_RUN);

    // column ring: cell 0 holds the run of the current column while the ring is aligned
    genvar k;
    generate
        for (k = 0; k < MAX_WIDTH; k++)
        begin : g_cell
            run_state_t nbr;
            if (k == MAX_WIDTH - 1)
            begin : g_end
                assign nbr = fb;
            end
            else
            begin : g_mid
                assign nbr = chain_q[k+1];
            end
            bircrl_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (COL_W'(k)),
                .ring_len (ring_len_reg),
                .shift    (shift),
                .nbr      (nbr),
                .fb       (fb),
                .q        (chain_q[k])
            );
        end
    endgenerate

    assign head = chain_q[0];

    // row and column run updates
    always_comb
    begin
        row_cnt_inc = (black && row_run_reg.cnt != COUNT_MAX) ?
                      row_run_reg.cnt + COUNT_W'(1) : row_run_reg.cnt;
        emit_r      = (!black || row_end) && (row_cnt_inc != '0);
        if (row_end)
            row_run_next = '0;
        else if (emit_r)
        begin
            row_run_next.cnt = '0;
            row_run_next.ord = row_run_reg.ord + ORD_W'(1);
        end
        else
        begin
            row_run_next.cnt = row_cnt_inc;
            row_run_next.ord = row_run_reg.ord;
        end

        col_cnt_inc = (black && head.cnt != COUNT_MAX) ? head.cnt + COUNT_W'(1) : head.cnt;
        emit_c      = (!black || col_end) && (col_cnt_inc != '0);
        if (col_end)
            col_upd = '0;
        else if (emit_c)
        begin
            col_upd.cnt = '0;
            col_upd.ord = head.ord + ORD_W'(1);
        end
        else
        begin
            col_upd.cnt = col_cnt_inc;
            col_upd.ord = head.ord;
        end
    end

    // during realignment the head entry travels unchanged
    assign fb = (state_reg == ST_RUN) ? col_upd : head;

    always_comb
    begin
        row_res.is_column  = 1'b0;
        row_res.line_index = LINE_W'(row_pos_reg);
        row_res.run_index  = row_run_reg.ord;
        row_res.run_length = row_cnt_inc;
        row_res.last       = !emit_c;

        col_res.is_column  = 1'b1;
        col_res.line_index = LINE_W'(col_pos_reg);
        col_res.run_index  = head.ord;
        col_res.run_length = col_cnt_inc;
        col_res.last       = 1'b1;

        push_a   = emit_r ? row_res : col_res;
        push_b   = col_res;
        push_cnt = accept ? (2'(emit_r) + 2'(emit_c)) : 2'd0;
    end

    bircrl_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b),
        .room     (room),
        .result   (result)
    );

    // raster position
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_pos_next = '0;
                row_pos_next = col_end ? '0 : row_pos_reg + ROW_W'(1);
            end
            else
                col_pos_next = col_pos_reg + COL_W'(1);
        end
    end

    // ring realignment: rotate back to column order, resize, rotate forward
    always_comb
    begin
        state_next    = state_reg;
        sw_next       = sw_reg;
        ring_len_next = ring_len_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (target != ring_len_reg)
                begin
                    if (col_pos_reg == '0)
                        ring_len_next = target;
                    else
                    begin
                        state_next = ST_DOWN;
                        sw_next    = col_pos_reg;
                    end
                end
                else if (accept && row_end)
                    ring_len_next = w_eff;
            end
            ST_DOWN:
            begin
                if ({1'b0, sw_reg} == (ring_len_reg - WSIZE_W'(1)))
                begin
                    ring_len_next = target;
                    sw_next       = '0;
                    state_next    = ST_UP;
                end
                else
                    sw_next = sw_reg + COL_W'(1);
            end
            ST_UP:
            begin
                if ((sw_reg + COL_W'(1)) == col_pos_reg)
                    state_next = ST_RUN;
                else
                    sw_next = sw_reg + COL_W'(1);
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            sw_reg       <= '0;
            ring_len_reg <= WSIZE_W'(MAX_WIDTH);
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            row_run_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sw_reg       <= sw_next;
            ring_len_reg <= ring_len_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            if (accept)
                row_run_reg <= row_run_next;
        end
    end

    a_ring_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_len_reg != '0 && ring_len_reg <= WSIZE_W'(MAX_WIDTH))
        else $error("column ring length out of range");

    a_col_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_pos_reg} < ring_len_reg)
        else $error("column position outside the ring");

    a_accept_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == ST_RUN) && (target == ring_len_reg))
        else $error("pixel taken while the ring is misaligned");

endmodule
